[rtl/iq_test_pattern_generator_assert.svh]
// ----------------------------------------------------------------------------
// IQ test pattern generator assertion macros
// Shared concurrent assertion forms used by the generator's RTL modules.
// ----------------------------------------------------------------------------
`ifndef IQ_TEST_PATTERN_GENERATOR_ASSERT_SVH
`define IQ_TEST_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITPG_ASSERT_NOW(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITPG_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/itpg_pkg.sv]
// ----------------------------------------------------------------------------
// itpg_pkg
// Types, register codes and constants shared by the IQ test pattern generator.
// ----------------------------------------------------------------------------
package itpg_pkg;

	// Fixed field widths and parameter defaults.
	localparam int SAMPLE_W         = 16;
	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int PATTERN_BITS_DEF = 8;

	// Configuration port geometry.
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	// Shared multiplier and divider sizes.
	localparam int MUL_A_W   = 31;
	localparam int MUL_B_W   = 16;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int DIV_NUM_W = 31;
	localparam int DIV_DEN_W = 12;

	// Pattern pulse level, 0.3 in Q1.15.
	localparam logic [MUL_B_W-1:0] PATTERN_LEVEL = 16'd9830;
	localparam logic [3:0]          MAX_PLACES    = 4'd8;
	localparam logic [3:0]          SYNC_PULSES   = 4'd3;

	// Operating modes.
	localparam logic [1:0] MODE_BINARY   = 2'd0;
	localparam logic [1:0] MODE_SAWTOOTH = 2'd1;
	localparam logic [1:0] MODE_SQUARE   = 2'd2;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	// Register indexes (byte address divided by four).
	localparam logic [REG_IDX_W-1:0] REG_MODE            = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PULSE_WIDTH     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_CYCLE   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_PLACES  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE_I     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE_Q     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE_DC    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PHASE_IMBALANCE = 3'd7;

	// Register reset values.
	localparam logic [1:0]  RST_MODE            = MODE_BINARY;
	localparam logic [11:0] RST_PULSE_WIDTH     = 12'd150;
	localparam logic [8:0]  RST_PATTERN_CYCLE   = 9'd8;
	localparam logic [3:0]  RST_PATTERN_PLACES  = 4'd3;
	localparam logic [15:0] RST_AMPLITUDE_I     = 16'd127;
	localparam logic [15:0] RST_AMPLITUDE_Q     = 16'd127;
	localparam logic [15:0] RST_AMPLITUDE_DC    = 16'd0;
	localparam logic [15:0] RST_PHASE_IMBALANCE = 16'd0;

	// Configuration register set as seen by the datapath.
	typedef struct packed {
		logic [1:0]         mode;
		logic [11:0]        pulse_width;
		logic [8:0]         pattern_cycle;
		logic [3:0]         pattern_places;
		logic signed [15:0] amplitude_i;
		logic signed [15:0] amplitude_q;
		logic signed [15:0] amplitude_dc;
		logic signed [15:0] phase_imbalance;
	} cfg_t;

endpackage

[rtl/itpg_regs.sv]
// ----------------------------------------------------------------------------
// itpg_regs
// APB-style configuration register file of the IQ test pattern generator.
// ----------------------------------------------------------------------------
module itpg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [itpg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [itpg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [itpg_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output itpg_pkg::cfg_t                  cfg
);
	import itpg_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	// Word index of the addressed register; the port never stalls.
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= RST_MODE;
			cfg_q.pulse_width     <= RST_PULSE_WIDTH;
			cfg_q.pattern_cycle   <= RST_PATTERN_CYCLE;
			cfg_q.pattern_places  <= RST_PATTERN_PLACES;
			cfg_q.amplitude_i     <= RST_AMPLITUDE_I;
			cfg_q.amplitude_q     <= RST_AMPLITUDE_Q;
			cfg_q.amplitude_dc    <= RST_AMPLITUDE_DC;
			cfg_q.phase_imbalance <= RST_PHASE_IMBALANCE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:            cfg_q.mode            <= pwdata[1:0];
				REG_PULSE_WIDTH:     cfg_q.pulse_width     <= pwdata[11:0];
				REG_PATTERN_CYCLE:   cfg_q.pattern_cycle   <= pwdata[8:0];
				REG_PATTERN_PLACES:  cfg_q.pattern_places  <= pwdata[3:0];
				REG_AMPLITUDE_I:     cfg_q.amplitude_i     <= pwdata[15:0];
				REG_AMPLITUDE_Q:     cfg_q.amplitude_q     <= pwdata[15:0];
				REG_AMPLITUDE_DC:    cfg_q.amplitude_dc    <= pwdata[15:0];
				REG_PHASE_IMBALANCE: cfg_q.phase_imbalance <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read data; signed registers come back sign-extended.
	always_comb begin
		case (reg_idx)
			REG_MODE:            prdata = {30'd0, cfg_q.mode};
			REG_PULSE_WIDTH:     prdata = {20'd0, cfg_q.pulse_width};
			REG_PATTERN_CYCLE:   prdata = {23'd0, cfg_q.pattern_cycle};
			REG_PATTERN_PLACES:  prdata = {28'd0, cfg_q.pattern_places};
			REG_AMPLITUDE_I:     prdata = {{16{cfg_q.amplitude_i[15]}}, cfg_q.amplitude_i};
			REG_AMPLITUDE_Q:     prdata = {{16{cfg_q.amplitude_q[15]}}, cfg_q.amplitude_q};
			REG_AMPLITUDE_DC:    prdata = {{16{cfg_q.amplitude_dc[15]}}, cfg_q.amplitude_dc};
			REG_PHASE_IMBALANCE: prdata = {{16{cfg_q.phase_imbalance[15]}},
				cfg_q.phase_imbalance};
			default:             prdata = '0;
		endcase
	end

endmodule

[rtl/itpg_mul.sv]
// ----------------------------------------------------------------------------
// itpg_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module itpg_mul (
	input  logic                         clk,
	input  logic [itpg_pkg::MUL_A_W-1:0] a,
	input  logic [itpg_pkg::MUL_B_W-1:0] b,
	output logic [itpg_pkg::MUL_P_W-1:0] p
);
	import itpg_pkg::*;

	logic [MUL_P_W-1:0] prod_q;

	// One product per cycle, available on the following cycle.
	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = prod_q;

endmodule

[rtl/itpg_div.sv]
// ----------------------------------------------------------------------------
// itpg_div
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "iq_test_pattern_generator_assert.svh"

module itpg_div #(
	parameter int NUM_W = itpg_pkg::DIV_NUM_W,
	parameter int DEN_W = itpg_pkg::DIV_DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import itpg_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// Shift the next dividend bit into the partial remainder and compare.
	assign trial = {rem_q, quot_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// Iteration control: NUM_W steps, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	`ITPG_ASSERT_NOW(a_div_no_restart_busy, clk, arst_n, start, !busy_q,
		"divider started while a division is in progress")
	`ITPG_ASSERT_NOW(a_div_den_nonzero, clk, arst_n, start, den != '0,
		"divider started with a zero divisor")

endmodule

[rtl/iq_test_pattern_generator.sv]
// ----------------------------------------------------------------------------
// iq_test_pattern_generator
// Test sample source with framed binary, sawtooth and square wave modes.
// ----------------------------------------------------------------------------
// Each accepted input transaction is one tick and yields at most one I/Q sample
// on the output channel. One item is processed at a time and in_ready is low
// while it is in work; a finished sample waits in the output register, so the
// next tick can be taken while it is still pending. Square mode runs the phase
// product, result and delivery states; binary mode adds the pulse boundary scan
// (one add and compare of the pulse width per cycle, up to pulse P + 3, P being
// the clamped place count) and the I and Q products, and its silent pulse skips
// delivery. Sawtooth mode makes two passes through the shared restoring divider
// at one quotient bit per cycle. Mode 3 ticks leave the sequencer idle. All
// products go through one shared multiplier with a registered output.
// ----------------------------------------------------------------------------
`include "iq_test_pattern_generator_assert.svh"

module iq_test_pattern_generator #(
	parameter int SAMPLE_BITS  = itpg_pkg::SAMPLE_BITS_DEF,
	parameter int PATTERN_BITS = itpg_pkg::PATTERN_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [itpg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [itpg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [itpg_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [itpg_pkg::SAMPLE_W-1:0] i_sample,
	output logic signed [itpg_pkg::SAMPLE_W-1:0] q_sample
);
	import itpg_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MPQ  = 11'b00000000010,
		S_PQ   = 11'b00000000100,
		S_SCAN = 11'b00000001000,
		S_MI   = 11'b00000010000,
		S_MQ   = 11'b00000100000,
		S_MR   = 11'b00001000000,
		S_DIVI = 11'b00010000000,
		S_DIVQ = 11'b00100000000,
		S_FIN  = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	function automatic logic [15:0] abs16(input logic [15:0] x);
		return x[15] ? 16'(~x + 16'd1) : x;
	endfunction

	function automatic logic [15:0] cneg16(input logic neg, input logic [15:0] x);
		return neg ? 16'(~x + 16'd1) : x;
	endfunction

	cfg_t cfg;

	state_t         state_q;
	logic [15:0]    sample_cnt_q;
	logic [7:0]     frame_cnt_q;
	logic [15:0]    acc_q;
	logic [3:0]     r_q;
	logic [30:0]    pq_q;
	logic [30:0]    pi_q;
	logic [30:0]    pqq_q;
	logic [15:0]    qi_q;
	logic [15:0]    qq_q;
	logic           res_has_q;
	logic [15:0]    res_i_q;
	logic [15:0]    res_q_q;
	logic           out_valid_q;
	logic [15:0]    i_sample_q;
	logic [15:0]    q_sample_q;

	logic [11:0]          w_eff;
	logic [3:0]           p_eff;
	logic [8:0]           cyc_eff;
	logic [3:0]           r_last;
	logic                 mode_bin;
	logic                 mode_saw;
	logic [16:0]          d;
	logic                 d_neg;
	logic [16:0]          d_mag;
	logic [15:0]          ph_mag;
	logic [15:0]          aq_mag;
	logic [15:0]          ai_mag;
	logic                 s_pq;
	logic [16:0]          k1;
	logic                 scan_stop;
	logic                 wrap;
	logic                 accept;
	logic                 out_free;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_p;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quot;
	logic                 fin_has;
	logic [15:0]          fin_i;
	logic [15:0]          fin_q;
	logic [3:0]           pat_idx;
	logic                 pat_bit;
	logic signed [SAMPLE_BITS-1:0] wrap_i;
	logic signed [SAMPLE_BITS-1:0] wrap_q;

	// Configuration registers.
	itpg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamped configuration and per-tick operands.
	assign w_eff    = (cfg.pulse_width == '0) ? 12'd1 : cfg.pulse_width;
	assign p_eff    = (cfg.pattern_places > MAX_PLACES) ? MAX_PLACES : cfg.pattern_places;
	assign cyc_eff  = (cfg.pattern_cycle == '0) ? 9'd1 : cfg.pattern_cycle;
	assign r_last   = SYNC_PULSES + p_eff;
	assign mode_bin = (cfg.mode == MODE_BINARY);
	assign mode_saw = (cfg.mode == MODE_SAWTOOTH);
	assign d        = {5'd0, w_eff} - {1'b0, sample_cnt_q};
	assign d_neg    = d[16];
	assign d_mag    = d_neg ? 17'(~d + 17'd1) : d;
	assign ph_mag   = abs16(cfg.phase_imbalance);
	assign aq_mag   = abs16(cfg.amplitude_q);
	assign ai_mag   = abs16(cfg.amplitude_i);
	assign s_pq     = cfg.phase_imbalance[15] ^ cfg.amplitude_q[15];
	assign k1       = {1'b0, sample_cnt_q} + 17'd1;

	// Handshake.
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign i_sample  = i_sample_q;
	assign q_sample  = q_sample_q;

	// Pulse boundary scan ends at the pulse holding k or at the silent pulse.
	assign scan_stop = (sample_cnt_q < acc_q) || (r_q == r_last);

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MPQ: begin
				mul_a = MUL_A_W'(ph_mag);
				mul_b = aq_mag;
			end
			S_MI: begin
				mul_a = MUL_A_W'(ai_mag);
				mul_b = mode_bin ? PATTERN_LEVEL : d_mag[15:0];
			end
			S_MQ: begin
				mul_a = pq_q;
				mul_b = mode_bin ? PATTERN_LEVEL : d_mag[15:0];
			end
			default: ;
		endcase
	end

	itpg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Sawtooth divides first the I product, then the scaled Q product.
	assign div_start = ((state_q == S_MR) && mode_saw) || ((state_q == S_DIVI) && div_done);
	assign div_num   = (state_q == S_MR) ? pi_q : pqq_q;

	itpg_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (w_eff),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sample selection from the gathered magnitudes and signs.
	always_comb begin
		fin_has = 1'b0;
		fin_i   = cfg.amplitude_dc;
		fin_q   = '0;
		pat_idx = r_q - SYNC_PULSES;
		pat_bit = (int'(pat_idx) < PATTERN_BITS) && frame_cnt_q[pat_idx[2:0]];
		case (cfg.mode)
			MODE_BINARY: begin
				fin_has = (r_q < r_last);
				if (r_q == 4'd1) begin
					fin_i = 16'(cfg.amplitude_i + cfg.amplitude_dc);
					fin_q = cneg16(s_pq, pq_q[30:15]);
				end else if ((r_q >= SYNC_PULSES) && pat_bit) begin
					fin_i = 16'(cneg16(cfg.amplitude_i[15], pi_q[30:15]) + cfg.amplitude_dc);
					fin_q = cneg16(s_pq, pqq_q[15:0]);
				end
			end
			MODE_SAWTOOTH: begin
				fin_has = 1'b1;
				fin_i   = 16'(cneg16(d_neg ^ cfg.amplitude_i[15], qi_q) + cfg.amplitude_dc);
				fin_q   = cneg16(d_neg ^ s_pq, qq_q);
			end
			MODE_SQUARE: begin
				fin_has = 1'b1;
				if (sample_cnt_q < {4'd0, w_eff}) begin
					fin_i = 16'(cfg.amplitude_i + cfg.amplitude_dc);
					fin_q = cneg16(s_pq, pq_q[30:15]);
				end
			end
			default: fin_has = 1'b0;
		endcase
	end

	// Counter wrap condition for the current mode.
	always_comb begin
		case (cfg.mode)
			MODE_BINARY:   wrap = (r_q == r_last) && (k1 >= {1'b0, acc_q});
			MODE_SAWTOOTH: wrap = k1 >= {5'd0, w_eff};
			MODE_SQUARE:   wrap = k1 >= {4'd0, w_eff, 1'b0};
			default:       wrap = 1'b0;
		endcase
	end

	// Wrap to the configured sample width, then sign-extend.
	assign wrap_i = fin_i[SAMPLE_BITS-1:0];
	assign wrap_q = fin_q[SAMPLE_BITS-1:0];

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sample_cnt_q <= '0;
			frame_cnt_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (restart) begin
							sample_cnt_q <= '0;
							frame_cnt_q  <= '0;
						end
						if (cfg.mode != MODE_RESERVED) begin
							state_q <= S_MPQ;
						end
					end
				end
				S_MPQ: state_q <= S_PQ;
				S_PQ: begin
					case (cfg.mode)
						MODE_BINARY:   state_q <= S_SCAN;
						MODE_SAWTOOTH: state_q <= S_MI;
						MODE_SQUARE:   state_q <= S_FIN;
						default:       state_q <= S_IDLE;
					endcase
				end
				S_SCAN: begin
					if (scan_stop) begin
						state_q <= S_MI;
					end
				end
				S_MI: state_q <= S_MQ;
				S_MQ: state_q <= S_MR;
				S_MR: state_q <= mode_saw ? S_DIVI : S_FIN;
				S_DIVI: begin
					if (div_done) begin
						state_q <= S_DIVQ;
					end
				end
				S_DIVQ: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (wrap) begin
						sample_cnt_q <= '0;
						if (mode_bin) begin
							frame_cnt_q <= ({1'b0, frame_cnt_q} + 9'd1 < cyc_eff) ?
								frame_cnt_q + 8'd1 : 8'd0;
						end
					end else begin
						sample_cnt_q <= k1[15:0];
					end
					state_q <= fin_has ? S_DONE : S_IDLE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_PQ: begin
				pq_q  <= mul_p[MUL_A_W-1:0];
				acc_q <= {4'd0, w_eff};
				r_q   <= '0;
			end
			S_SCAN: begin
				if (!scan_stop) begin
					acc_q <= acc_q + {4'd0, w_eff};
					r_q   <= r_q + 4'd1;
				end
			end
			S_MQ: pi_q <= mul_p[MUL_A_W-1:0];
			S_MR: pqq_q <= mode_bin ? MUL_A_W'(mul_p >> 30) : MUL_A_W'(mul_p >> 15);
			S_DIVI: begin
				if (div_done) begin
					qi_q <= div_quot[15:0];
				end
			end
			S_DIVQ: begin
				if (div_done) begin
					qq_q <= div_quot[15:0];
				end
			end
			S_FIN: begin
				res_has_q <= fin_has;
				res_i_q   <= SAMPLE_W'(wrap_i);
				res_q_q   <= SAMPLE_W'(wrap_q);
			end
			default: ;
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free && res_has_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			i_sample_q <= res_i_q;
			q_sample_q <= res_q_q;
		end
	end

	`ITPG_ASSERT_NEXT(a_busy_after_accept, clk, arst_n,
		accept && (cfg.mode != MODE_RESERVED), !in_ready,
		"input accepted but block did not go busy")
	`ITPG_ASSERT_NOW(a_out_from_done, clk, arst_n, $rose(out_valid_q),
		$past(state_q == S_DONE), "output loaded outside the delivery state")
	`ITPG_ASSERT_NOW(a_div_done_expected, clk, arst_n, div_done,
		(state_q == S_DIVI) || (state_q == S_DIVQ),
		"divider finished while the sequencer was not waiting for it")

endmodule

[bench/tb_iq_test_pattern_generator.sv]
// ----------------------------------------------------------------------------
// tb_iq_test_pattern_generator
// Self-checking bench for the I/Q test pattern generator. Tick transactions
// are fed to the block and each sample that comes back is compared, in order,
// with the output of a behavioral generator model kept inside the bench. The
// run covers directed corner settings, a long binary run that wraps the frame
// counter, and randomized settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_iq_test_pattern_generator;
	timeunit 1ns;
	timeprecision 1ps;

	import itpg_pkg::*;

	localparam int DRAIN_CYCLES  = 200;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_TICKS  = 1150;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic signed [15:0] i;
		logic signed [15:0] q;
	} iq_pair_t;

	// Clock, reset and block ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] i_sample;
	logic signed [SAMPLE_W-1:0] q_sample;

	// Bench bookkeeping.
	logic tick_queue[$];
	iq_pair_t predicted_iq[$];
	int ticks_queued = 0;
	int ticks_accepted = 0;
	int errors = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int send_idle;
	int recv_idle;

	// Shadow copy of the generator registers and counters.
	logic [1:0] gen_mode;
	logic [11:0] gen_width;
	logic [8:0] gen_cycle;
	logic [3:0] gen_places;
	logic signed [15:0] gen_amp_i;
	logic signed [15:0] gen_amp_q;
	logic signed [15:0] gen_dc;
	logic signed [15:0] gen_phase;
	logic [15:0] tick_count = '0;
	logic [7:0] frame_count = '0;

	iq_test_pattern_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.i_sample(i_sample),
		.q_sample(q_sample)
	);

	always #6 clk = ~clk;

	// Stall regimes: receiver-heavy gaps first, sender-heavy next, then none.
	assign send_idle = (ticks_accepted < 400) ? 19 : (ticks_accepted < 800) ? 61 : 0;
	assign recv_idle = (ticks_accepted < 400) ? 61 : (ticks_accepted < 800) ? 19 : 0;

	// Advance the generator model by one tick and queue the sample it yields.
	task automatic advance_generator(input logic clear);
		longint w, p, cyc, k, d, frame, fc, iv, qv;
		int idx;
		logic has_out;
		begin
			w = (gen_width == 0) ? 1 : gen_width;
			p = (gen_places > MAX_PLACES) ? MAX_PLACES : gen_places;
			cyc = (gen_cycle == 0) ? 1 : gen_cycle;
			if (clear) begin
				tick_count = '0;
				frame_count = '0;
			end
			k = tick_count;
			fc = frame_count;
			has_out = 1'b0;
			iv = 0;
			qv = 0;
			case (gen_mode)
				MODE_BINARY: begin
					frame = (4 + p) * w;
					if (k < w || (k >= 2 * w && k < 3 * w)) begin
						iv = gen_dc;
						has_out = 1'b1;
					end else if (k < 2 * w) begin
						iv = longint'(gen_amp_i) + gen_dc;
						qv = (longint'(gen_phase) * gen_amp_q) / 32768;
						has_out = 1'b1;
					end else if (k < (3 + p) * w) begin
						// Pattern places carry the frame counter, LSB first.
						idx = int'((k - 3 * w) / w);
						if (idx < PATTERN_BITS_DEF && frame_count[idx]) begin
							iv = (longint'(PATTERN_LEVEL) * gen_amp_i) / 32768 + gen_dc;
							qv = (longint'(PATTERN_LEVEL) * gen_phase * gen_amp_q) /
								(longint'(1) << 30);
						end else begin
							iv = gen_dc;
						end
						has_out = 1'b1;
					end
					// The silent pulse and any stale count past it give nothing.
					if (k + 1 < frame) begin
						tick_count = 16'(k + 1);
					end else begin
						tick_count = '0;
						frame_count = 8'((fc + 1 < cyc) ? fc + 1 : 0);
					end
				end
				MODE_SAWTOOTH: begin
					d = w - k;
					iv = (d * gen_amp_i) / w + gen_dc;
					qv = (longint'(gen_phase) * d * gen_amp_q) / (32768 * w);
					has_out = 1'b1;
					tick_count = 16'((k + 1 < w) ? k + 1 : 0);
				end
				MODE_SQUARE: begin
					if (k < w) begin
						iv = longint'(gen_amp_i) + gen_dc;
						qv = (longint'(gen_phase) * gen_amp_q) / 32768;
					end else begin
						iv = gen_dc;
					end
					has_out = 1'b1;
					tick_count = 16'((k + 1 < 2 * w) ? k + 1 : 0);
				end
				default: begin
					// Reserved mode holds the counters and yields nothing.
				end
			endcase
			if (has_out)
				predicted_iq.push_back('{i: iv[15:0], q: qv[15:0]});
		end
	endtask

	// Tick driver: holds each transaction until accepted, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			ticks_accepted <= 0;
		end else begin
			if (in_valid && in_ready) begin
				advance_generator(restart);
				ticks_accepted <= ticks_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					restart <= tick_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Sample receiver: random back-pressure plus one long hold-off when armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done && in_valid) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Output monitor: compare each sample with the oldest prediction.
	always @(posedge clk) begin : check_output
		iq_pair_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_iq.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("Unexpected sample: i=%0d q=%0d", i_sample, q_sample);
			end else begin
				want = predicted_iq.pop_front();
				if (want.i !== i_sample || want.q !== q_sample) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("Sample mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
							want.i, want.q, i_sample, q_sample);
				end
			end
		end
	end

	// Watchdog: give up when no transaction moves for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// One register write: setup cycle, then access cycle.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= value;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			case (idx)
				REG_MODE:            gen_mode = value[1:0];
				REG_PULSE_WIDTH:     gen_width = value[11:0];
				REG_PATTERN_CYCLE:   gen_cycle = value[8:0];
				REG_PATTERN_PLACES:  gen_places = value[3:0];
				REG_AMPLITUDE_I:     gen_amp_i = value[15:0];
				REG_AMPLITUDE_Q:     gen_amp_q = value[15:0];
				REG_AMPLITUDE_DC:    gen_dc = value[15:0];
				REG_PHASE_IMBALANCE: gen_phase = value[15:0];
				default: ;
			endcase
		end
	endtask

	// Write the whole register set.
	task automatic program_generator(input logic [1:0] mode, input logic [11:0] width,
		input logic [8:0] cycle, input logic [3:0] places, input logic [15:0] amp_i,
		input logic [15:0] amp_q, input logic [15:0] dc, input logic [15:0] phase);
		begin
			write_reg(REG_MODE, {30'd0, mode});
			write_reg(REG_PULSE_WIDTH, {20'd0, width});
			write_reg(REG_PATTERN_CYCLE, {23'd0, cycle});
			write_reg(REG_PATTERN_PLACES, {28'd0, places});
			write_reg(REG_AMPLITUDE_I, {{16{amp_i[15]}}, amp_i});
			write_reg(REG_AMPLITUDE_Q, {16'd0, amp_q});
			write_reg(REG_AMPLITUDE_DC, {{16{dc[15]}}, dc});
			write_reg(REG_PHASE_IMBALANCE, {16'd0, phase});
		end
	endtask

	// Queue ticks: the first with a given restart bit, the rest at random.
	task automatic queue_ticks(input int count, input logic first_clear, input int clear_pct);
		begin
			for (int n = 0; n < count; n++) begin
				tick_queue.push_back((n == 0) ? first_clear : ($urandom_range(99) < clear_pct));
				ticks_queued++;
			end
		end
	endtask

	// Wait until every tick is taken and every sample is back, then let the
	// block finish any tick that yields nothing.
	task automatic settle();
		begin
			do
				@(posedge clk);
			while (ticks_accepted != ticks_queued || predicted_iq.size() != 0);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_amplitude();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_width();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 12'd0;
		else if (r < 12)
			return 12'd4095;
		else if (r < 22)
			return 12'($urandom_range(4095));
		else
			return 12'($urandom_range(1, 6));
	endfunction

	// Stimulus sequence.
	initial begin
		gen_mode = RST_MODE;
		gen_width = RST_PULSE_WIDTH;
		gen_cycle = RST_PATTERN_CYCLE;
		gen_places = RST_PATTERN_PLACES;
		gen_amp_i = RST_AMPLITUDE_I;
		gen_amp_q = RST_AMPLITUDE_Q;
		gen_dc = RST_AMPLITUDE_DC;
		gen_phase = RST_PHASE_IMBALANCE;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two short binary frames at full-scale extremes; pattern bit set in
		// the second frame, silent pulse at the end of each.
		program_generator(MODE_BINARY, 12'd1, 9'd2, 4'd2, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		queue_ticks(12, 1'b1, 0);
		settle();

		// Sawtooth with zero width, zero cycle and too many places.
		program_generator(MODE_SAWTOOTH, 12'd0, 9'd0, 4'd15, 16'h8000, 16'h7fff, 16'h7fff,
			16'h8000);
		queue_ticks(3, 1'b1, 0);
		settle();

		// Square wave with a large pattern cycle written.
		program_generator(MODE_SQUARE, 12'd2, 9'd300, 4'd8, 16'h0001, 16'hffff, 16'h8000,
			16'hffff);
		queue_ticks(5, 1'b0, 0);
		settle();

		// Reserved mode yields nothing; restart still clears.
		program_generator(MODE_RESERVED, 12'd3, 9'd511, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		queue_ticks(2, 1'b1, 0);
		settle();

		// Run 255 short frames, then widen to eight places so the frame count
		// of 255 shows on the pattern before the counter wraps to zero.
		program_generator(MODE_BINARY, 12'd1, 9'd300, 4'd0, 16'd20000, 16'hcfc7, 16'd100,
			16'd16384);
		queue_ticks(1020, 1'b1, 0);
		settle();
		write_reg(REG_PATTERN_PLACES, 32'd8);
		queue_ticks(24, 1'b0, 0);
		settle();

		// Random settings, mostly short pulses so frames stay short.
		while (ticks_queued < RANDOM_TICKS) begin
			program_generator(
				($urandom_range(99) < 8) ? MODE_RESERVED : 2'($urandom_range(2)),
				pick_width(),
				($urandom_range(99) < 10) ? 9'd0 :
					($urandom_range(99) < 12) ? 9'($urandom_range(511)) :
					9'($urandom_range(1, 4)),
				($urandom_range(99) < 20) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8)),
				pick_amplitude(), pick_amplitude(), pick_amplitude(), pick_amplitude());
			queue_ticks($urandom_range(10, 60), 1'($urandom_range(1)), 4);
			settle();
		end

		// Long receiver hold-off while ticks keep coming, so the input stalls.
		program_generator(MODE_SQUARE, 12'd3, 9'd4, 4'd3, pick_amplitude(), pick_amplitude(),
			pick_amplitude(), pick_amplitude());
		hold_arm = 1'b1;
		queue_ticks(40, 1'b0, 4);
		settle();

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
